// ===== src/atr_pkg.sv =====
// Shared constants and types for the average true range block.
package atr_pkg;

  localparam int TR_BITS   = 32;   // width of the true range in a result word
  localparam int AVG_BITS  = 40;   // width of the fixed-point average
  localparam int FRAC_BITS = 8;    // fractional bits of the average
  localparam int LEN_BITS  = 7;    // width of the window length register

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(14);

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/atr_ifs.sv =====
// Valid/ready channel interfaces for price bars and results.
interface atr_bar_if #(
  parameter int PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic [PRICE_BITS-1:0] bar_close;
  logic                  first_of_series;

  modport source (output valid, bar_high, bar_low, bar_close, first_of_series, input ready);
  modport sink   (input valid, bar_high, bar_low, bar_close, first_of_series, output ready);
endinterface

interface atr_res_if;
  import atr_pkg::*;

  logic                valid;
  logic                ready;
  logic [TR_BITS-1:0]  true_range;
  logic [AVG_BITS-1:0] avg_true_range;
  logic                avg_valid;

  modport source (output valid, true_range, avg_true_range, avg_valid, input ready);
  modport sink   (input valid, true_range, avg_true_range, avg_valid, output ready);
endinterface

// ===== src/average_true_range.sv =====
// Top level of the average true range block: sequencer, range history, divider and output register.
//
//   Channel   Dir   Handshake          Word
//   bar_i     in    valid/ready        bar_high, bar_low, bar_close, first_of_series
//   res_o     out   valid/ready        true_range, avg_true_range, avg_valid
//   cfg       in    cfg_we_i           window_length
//
// An accepted bar passes through the range, retire and add states; a word with a valid
// average then waits for the bit-serial divider, while a word without one goes straight to
// the output register. Input ready returns together with the result word.
// The history RAM is read, then written back, on separate cycles, so no entry is
// read and written at once. Reset needs no clearing pass. A new bar is taken while
// a finished result waits; the block stalls before its own result if that word is
// still unclaimed.
module average_true_range #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [atr_pkg::LEN_BITS-1:0]  cfg_wdata_i,
  atr_bar_if.sink                       bar_i,
  atr_res_if.source                     res_o
);
  import atr_pkg::*;

  localparam int IW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int SW = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int DW = SW + FRAC_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RANGE  = 3'd1;
  localparam logic [2:0] ST_RETIRE = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_START  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [SW-1:0]         sum_q, sum_d;
  logic [PRICE_BITS-1:0] prev_q, prev_d;
  logic [LW-1:0]         bars_q, bars_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic                  out_valid_q, out_valid_d;

  // Working registers of the word in flight.
  logic [PRICE_BITS-1:0] hi_q, lo_q, cl_q;
  logic [PRICE_BITS-1:0] tr_q, tr_d;
  logic                  full_q, full_d;
  logic                  valid_q, valid_d;
  logic [TR_BITS-1:0]    tr_out_q, tr_out_d;
  logic [AVG_BITS-1:0]   avg_out_q, avg_out_d;
  logic                  avgv_out_q, avgv_out_d;

  logic                  bar_acc;
  logic                  out_free;
  logic [LW-1:0]         len_eff;
  logic [LW:0]           slot_w;
  logic [IW-1:0]         leave_addr;
  logic [PRICE_BITS-1:0] hl, dh, dl;
  logic                  ram_we, ram_re;
  logic [PRICE_BITS-1:0] ram_rdata;
  logic                  div_start;
  logic [DW-1:0]         div_quo;
  div_status_t           div_st;

  assign bar_acc  = bar_i.valid && bar_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(len_q) > 32'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(len_q);
    end
  end

  // Slot of the range that drops out of the window.
  assign slot_w = (LW + 1)'(slot_q);
  always_comb begin
    if (slot_w >= (LW + 1)'(len_eff)) begin
      leave_addr = IW'(slot_w - (LW + 1)'(len_eff));
    end else begin
      leave_addr = IW'(slot_w + (LW + 1)'(MAX_WINDOW) - (LW + 1)'(len_eff));
    end
  end

  assign hl = (hi_q >= lo_q) ? hi_q - lo_q : '0;
  assign dh = (hi_q >= prev_q) ? hi_q - prev_q : prev_q - hi_q;
  assign dl = (lo_q >= prev_q) ? lo_q - prev_q : prev_q - lo_q;

  always_comb begin
    tr_d = hl;
    if (bars_q != '0) begin
      if (dh > tr_d) begin
        tr_d = dh;
      end
      if (dl > tr_d) begin
        tr_d = dl;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    sum_d       = sum_q;
    prev_d      = prev_q;
    bars_d      = bars_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    full_d      = full_q;
    valid_d     = valid_q;
    tr_out_d    = tr_out_q;
    avg_out_d   = avg_out_q;
    avgv_out_d  = avgv_out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;

    if (res_o.valid && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    // A length write restarts the history but keeps the previous close.
    if (cfg_we_i) begin
      len_d  = cfg_wdata_i;
      sum_d  = '0;
      bars_d = '0;
      slot_d = '0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (bar_acc) begin
          if (bar_i.first_of_series) begin
            sum_d  = '0;
            bars_d = '0;
            slot_d = '0;
          end
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        ram_re  = 1'b1;
        full_d  = bars_q >= len_eff;
        state_d = ST_RETIRE;
      end
      ST_RETIRE: begin
        if (full_q) begin
          sum_d = sum_q - SW'(ram_rdata);
        end
        ram_we  = 1'b1;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        sum_d  = sum_q + SW'(tr_q);
        slot_d = (slot_q == IW'(MAX_WINDOW - 1)) ? '0 : slot_q + IW'(1);
        if (!full_q) begin
          bars_d = bars_q + LW'(1);
        end
        prev_d  = cl_q;
        valid_d = full_q || ((bars_q + LW'(1)) == len_eff);
        state_d = (full_q || ((bars_q + LW'(1)) == len_eff)) ? ST_START : ST_DONE;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          tr_out_d    = TR_BITS'(tr_q);
          avg_out_d   = valid_q ? AVG_BITS'(div_quo) : '0;
          avgv_out_d  = valid_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_RESET;
      sum_q       <= '0;
      prev_q      <= '0;
      bars_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
      bars_q      <= bars_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bar_acc) begin
      hi_q <= bar_i.bar_high;
      lo_q <= bar_i.bar_low;
      cl_q <= bar_i.bar_close;
    end
    if (state_q == ST_RANGE) begin
      tr_q <= tr_d;
    end
    full_q     <= full_d;
    valid_q    <= valid_d;
    tr_out_q   <= tr_out_d;
    avg_out_q  <= avg_out_d;
    avgv_out_q <= avgv_out_d;
  end

  atr_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (tr_q),
    .re_i    (ram_re),
    .raddr_i (leave_addr),
    .rdata_o (ram_rdata)
  );

  atr_div #(
    .DW (DW),
    .LW (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, FRAC_BITS'(0)}),
    .divisor_i  (len_eff),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign bar_i.ready          = (state_q == ST_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.true_range     = tr_out_q;
  assign res_o.avg_true_range = avg_out_q;
  assign res_o.avg_valid      = avgv_out_q;

  // A word without a valid average carries a zero average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.avg_valid |-> res_o.avg_true_range == '0)
    else $error("average is nonzero while not valid");

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_START |-> !div_st.busy)
    else $error("divider started while busy");

  // The bar count never runs past the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bars_q <= len_eff)
    else $error("bar count exceeds window length");

  // An unclaimed result word is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !res_o.ready |=> state_q == ST_DONE)
    else $error("result word overwritten before it was taken");

endmodule

// ===== src/atr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module atr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/atr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module atr_div #(
  parameter int DW = 46,
  parameter int LW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [LW-1:0]             divisor_i,
  output logic [DW-1:0]             quotient_o,
  output atr_pkg::div_status_t      status_o
);
  import atr_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [LW-1:0] dvs_q, dvs_d;
  logic [LW:0]   shifted;
  logic [LW:0]   diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so the difference fits LW bits.
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = LW'(diff);
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = LW'(shifted);
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
